>>> sv/calendar_clock_counter_top_defines.svh
// Assertion helpers shared by the calendar clock RTL.
// All checks are clocked on clk_i and are off while rst_ni is low.
`ifndef CALENDAR_CLOCK_COUNTER_TOP_DEFINES_SVH
`define CALENDAR_CLOCK_COUNTER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge.
`define CCC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define CCC_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define CCC_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ccc_pkg.sv
package ccc_pkg;

  localparam int unsigned YearBitsDef = 14;
  localparam int unsigned YearReset = 2000;
  localparam int unsigned CenturyOddPart = 25;

  // Multiplicative inverse of 25 modulo 2^16; its low bits are the inverse for narrower words.
  localparam logic [15:0] Inv25 = 16'd23593;

  localparam logic [5:0] SecLast = 6'd59;
  localparam logic [5:0] MinLast = 6'd59;
  localparam logic [5:0] SecPerMin = 6'd60;
  localparam logic [5:0] MinPerHour = 6'd60;
  localparam logic [5:0] HourPerDay = 6'd24;
  localparam logic [4:0] HourLast = 5'd23;
  localparam logic [4:0] HalfDay = 5'd12;
  localparam logic [3:0] MonthLast = 4'd12;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SET_TIME = 2'd1,
    CMD_SET_DATE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]             command;
    logic [5:0]             new_hour;
    logic [5:0]             new_minute;
    logic [5:0]             new_second;
    logic [4:0]             new_day;
    logic [3:0]             new_month;
    logic [YearBitsDef-1:0] new_year;
  } req_t;

  typedef struct packed {
    logic [5:0]             second_now;
    logic [5:0]             minute_now;
    logic [4:0]             hour_now;
    logic [3:0]             hour_twelve;
    logic                   is_pm;
    logic [4:0]             day_now;
    logic [3:0]             month_now;
    logic [YearBitsDef-1:0] year_now;
  } rsp_t;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    case (month)
      4'd2: begin
        days = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        days = 5'd30;
      end
      default: begin
        days = 5'd31;
      end
    endcase
    return days;
  endfunction

endpackage

>>> sv/ccc_month_len.sv
module ccc_month_len #(
  parameter int unsigned YEAR_BITS = ccc_pkg::YearBitsDef
) (
  input  logic [YEAR_BITS-1:0] year_i,
  input  logic [3:0]           month_i,
  output logic [4:0]           days_o
);

  localparam logic [YEAR_BITS-1:0] InvMod = YEAR_BITS'(ccc_pkg::Inv25);
  localparam logic [YEAR_BITS-1:0] Div25Limit =
    YEAR_BITS'(((2 ** YEAR_BITS) - 1) / ccc_pkg::CenturyOddPart);

  logic [YEAR_BITS-1:0] scaled;
  logic                 by25;
  logic                 by4;
  logic                 by16;
  logic                 leap;

  // A year is a multiple of 25 exactly when its product with the modular inverse stays small.
  assign scaled = year_i * InvMod;
  assign by25   = (scaled <= Div25Limit);
  assign by4    = (year_i[1:0] == 2'd0);
  assign by16   = (year_i[3:0] == 4'd0);
  assign leap   = by25 ? by16 : by4;
  assign days_o = ccc_pkg::month_days(month_i, leap);

endmodule

>>> sv/calendar_clock_counter_top.sv
// Calendar clock with second, minute, hour, day, month and year. Each request is a tick, a
// set-time or a set-date command (other codes leave the time as it is) and returns one result
// with the time after the update. One request can be taken in every clock cycle while results
// are not stalled; a request goes to the input register, then its result to the result
// register, where it waits for the receiver. The rate is set by the loop that updates the
// time registers through the leap-year test and month-length lookup.
`include "calendar_clock_counter_top_defines.svh"

module calendar_clock_counter_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ccc_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ccc_pkg::rsp_t out_rsp_o
);

  localparam int unsigned YearBits = ccc_pkg::YearBitsDef;
  localparam logic [YearBits-1:0] YearMax = {YearBits{1'b1}};
  localparam logic [YearBits-1:0] YearInit = YearBits'(ccc_pkg::YearReset);

  logic          in_valid_q, in_valid_d;
  ccc_pkg::req_t in_q;
  logic          out_valid_q, out_valid_d;
  ccc_pkg::rsp_t out_q, out_d;
  logic          in_take;
  logic          out_load;

  logic [5:0]          seconds_q, seconds_d;
  logic [5:0]          minutes_q, minutes_d;
  logic [4:0]          hours_q, hours_d;
  logic [4:0]          day_q, day_d;
  logic [3:0]          month_q, month_d;
  logic [YearBits-1:0] year_q, year_d;

  logic [YearBits-1:0] set_year;
  logic [YearBits-1:0] year_sel;
  logic [3:0]          month_sel;
  logic [4:0]          days;
  logic [4:0]          hour_half;

  assign out_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !out_load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (out_load) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // A set-date checks the day against the month and year it leaves behind.
  always_comb begin
    set_year  = in_q.new_year;
    year_sel  = year_q;
    month_sel = month_q;
    if (in_q.command == ccc_pkg::CMD_SET_DATE) begin
      if (set_year != '0) begin
        year_sel = set_year;
      end
      if ((in_q.new_month != 4'd0) && (in_q.new_month <= ccc_pkg::MonthLast)) begin
        month_sel = in_q.new_month;
      end
    end
  end

  ccc_month_len #(
    .YEAR_BITS(YearBits)
  ) u_month_len (
    .year_i (year_sel),
    .month_i(month_sel),
    .days_o (days)
  );

  always_comb begin
    seconds_d = seconds_q;
    minutes_d = minutes_q;
    hours_d   = hours_q;
    day_d     = day_q;
    month_d   = month_q;
    year_d    = year_q;
    case (ccc_pkg::cmd_e'(in_q.command))
      ccc_pkg::CMD_TICK: begin
        if (seconds_q < ccc_pkg::SecLast) begin
          seconds_d = seconds_q + 6'd1;
        end else if (minutes_q < ccc_pkg::MinLast) begin
          minutes_d = minutes_q + 6'd1;
          seconds_d = '0;
        end else if (hours_q < ccc_pkg::HourLast) begin
          hours_d   = hours_q + 5'd1;
          minutes_d = '0;
          seconds_d = '0;
        end else begin
          hours_d   = '0;
          minutes_d = '0;
          seconds_d = '0;
          if (day_q < days) begin
            day_d = day_q + 5'd1;
          end else if (month_q < ccc_pkg::MonthLast) begin
            month_d = month_q + 4'd1;
            day_d   = 5'd1;
          end else begin
            if (year_q != YearMax) begin
              year_d = year_q + YearBits'(1);
            end
            month_d = 4'd1;
            day_d   = 5'd1;
          end
        end
      end
      ccc_pkg::CMD_SET_TIME: begin
        if (in_q.new_hour < ccc_pkg::HourPerDay) begin
          hours_d = in_q.new_hour[4:0];
        end
        if (in_q.new_minute < ccc_pkg::MinPerHour) begin
          minutes_d = in_q.new_minute;
        end
        if (in_q.new_second < ccc_pkg::SecPerMin) begin
          seconds_d = in_q.new_second;
        end
      end
      ccc_pkg::CMD_SET_DATE: begin
        year_d  = year_sel;
        month_d = month_sel;
        if ((in_q.new_day != 5'd0) && (in_q.new_day <= days)) begin
          day_d = in_q.new_day;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    hour_half = (hours_d >= ccc_pkg::HalfDay) ? (hours_d - ccc_pkg::HalfDay) : hours_d;
    out_d.second_now  = seconds_d;
    out_d.minute_now  = minutes_d;
    out_d.hour_now    = hours_d;
    out_d.hour_twelve = (hour_half == 5'd0) ? 4'd12 : hour_half[3:0];
    out_d.is_pm       = (hours_d >= ccc_pkg::HalfDay);
    out_d.day_now     = day_d;
    out_d.month_now   = month_d;
    out_d.year_now    = year_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seconds_q   <= '0;
      minutes_q   <= '0;
      hours_q     <= '0;
      day_q       <= 5'd1;
      month_q     <= 4'd1;
      year_q      <= YearInit;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        seconds_q <= seconds_d;
        minutes_q <= minutes_d;
        hours_q   <= hours_d;
        day_q     <= day_d;
        month_q   <= month_d;
        year_q    <= year_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_req_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `CCC_ASSERT(a_time_range,
    (seconds_q <= ccc_pkg::SecLast) && (minutes_q <= ccc_pkg::MinLast)
      && (hours_q <= ccc_pkg::HourLast),
    "Time registers out of range.")
  `CCC_ASSERT(a_date_range,
    (month_q != 4'd0) && (month_q <= ccc_pkg::MonthLast) && (day_q != 5'd0),
    "Date registers out of range.")
  `CCC_NEXT(a_state_hold, out_valid_q && out_stall_i,
    $stable(seconds_q) && $stable(day_q) && $stable(year_q),
    "Time changed while the result was stalled.")
  `CCC_NEXT(a_tick_second,
    out_load && (in_q.command == ccc_pkg::CMD_TICK) && (seconds_q < ccc_pkg::SecLast),
    seconds_q == $past(seconds_q) + 6'd1,
    "Tick did not advance the second.")
  `CCC_IMPLY(a_pm_flag, out_valid_q,
    out_q.is_pm == (out_q.hour_now >= ccc_pkg::HalfDay),
    "PM flag disagrees with the hour.")

endmodule

>>> verif/tb_calendar_clock_counter_top.sv
`timescale 1ns / 1ps

module tb_calendar_clock_counter_top;
  import ccc_pkg::*;

  localparam int unsigned YearMax = (1 << YearBitsDef) - 1;
  localparam logic [1:0] CmdUnknown = 2'd3;
  localparam int unsigned RandomReqs = 500;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned DrainCycles = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  calendar_clock_counter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  req_t pending_q[$];
  rsp_t clock_exp_q[$];

  int unsigned cal_sec = 0;
  int unsigned cal_min = 0;
  int unsigned cal_hour = 0;
  int unsigned cal_day = 1;
  int unsigned cal_month = 1;
  int unsigned cal_year = YearReset;

  int unsigned sent_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned tick_cnt = 0;
  int unsigned set_time_cnt = 0;
  int unsigned set_date_cnt = 0;
  int unsigned unknown_cnt = 0;
  int unsigned month_turns = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  int unsigned mode_left = 0;
  int unsigned stall_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      2: return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // Applies one request to the calendar state and returns the time that follows it.
  function automatic rsp_t clock_after(req_t r);
    rsp_t o;
    int unsigned h12;
    case (r.command)
      CMD_TICK: begin
        if (cal_sec < 59) begin
          cal_sec++;
        end else begin
          cal_sec = 0;
          if (cal_min < 59) begin
            cal_min++;
          end else begin
            cal_min = 0;
            if (cal_hour < 23) begin
              cal_hour++;
            end else begin
              cal_hour = 0;
              if (cal_day < days_in_month(cal_month, cal_year)) begin
                cal_day++;
              end else begin
                cal_day = 1;
                month_turns++;
                if (cal_month < 12) begin
                  cal_month++;
                end else begin
                  cal_month = 1;
                  if (cal_year < YearMax) cal_year++;
                end
              end
            end
          end
        end
      end
      CMD_SET_TIME: begin
        if (r.new_hour < 24) cal_hour = 32'(r.new_hour);
        if (r.new_minute < 60) cal_min = 32'(r.new_minute);
        if (r.new_second < 60) cal_sec = 32'(r.new_second);
      end
      CMD_SET_DATE: begin
        if ((32'(r.new_year) & YearMax) != 0) cal_year = 32'(r.new_year) & YearMax;
        if (r.new_month >= 1 && r.new_month <= 12) cal_month = 32'(r.new_month);
        if (r.new_day >= 1 && r.new_day <= days_in_month(cal_month, cal_year)) begin
          cal_day = 32'(r.new_day);
        end
      end
      default: ;
    endcase
    h12 = cal_hour % 12;
    if (h12 == 0) h12 = 12;
    o.second_now = 6'(cal_sec);
    o.minute_now = 6'(cal_min);
    o.hour_now = 5'(cal_hour);
    o.hour_twelve = 4'(h12);
    o.is_pm = (cal_hour >= 12);
    o.day_now = 5'(cal_day);
    o.month_now = 4'(cal_month);
    o.year_now = 14'(cal_year);
    return o;
  endfunction

  task automatic check_result(rsp_t got, rsp_t want);
    if (got.second_now !== want.second_now)
      report_error($sformatf("second %0d, expected %0d", got.second_now, want.second_now));
    if (got.minute_now !== want.minute_now)
      report_error($sformatf("minute %0d, expected %0d", got.minute_now, want.minute_now));
    if (got.hour_now !== want.hour_now)
      report_error($sformatf("hour %0d, expected %0d", got.hour_now, want.hour_now));
    if (got.hour_twelve !== want.hour_twelve)
      report_error($sformatf("12-hour %0d, expected %0d", got.hour_twelve, want.hour_twelve));
    if (got.is_pm !== want.is_pm)
      report_error($sformatf("pm flag %0d, expected %0d", got.is_pm, want.is_pm));
    if (got.day_now !== want.day_now)
      report_error($sformatf("day %0d, expected %0d", got.day_now, want.day_now));
    if (got.month_now !== want.month_now)
      report_error($sformatf("month %0d, expected %0d", got.month_now, want.month_now));
    if (got.year_now !== want.year_now)
      report_error($sformatf("year %0d, expected %0d", got.year_now, want.year_now));
  endtask

  task automatic add_req(logic [1:0] cmd, int unsigned h, int unsigned mi, int unsigned s,
                         int unsigned d, int unsigned mo, int unsigned y);
    req_t r;
    r.command = cmd;
    r.new_hour = 6'(h);
    r.new_minute = 6'(mi);
    r.new_second = 6'(s);
    r.new_day = 5'(d);
    r.new_month = 4'(mo);
    r.new_year = 14'(y);
    pending_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        case (in_req_i.command)
          CMD_TICK: tick_cnt++;
          CMD_SET_TIME: set_time_cnt++;
          CMD_SET_DATE: set_date_cnt++;
          default: unknown_cnt++;
        endcase
        clock_exp_q.push_back(clock_after(in_req_i));
        sent_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          in_req_i <= pending_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 10);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // The receiver changes its stall rate now and then, and once holds off for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && sent_cnt >= 150) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(5, 40);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (clock_exp_q.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        check_result(out_rsp_o, clock_exp_q.pop_front());
      end
      checked_cnt++;
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timed out after %0d cycles.", cycle_cnt);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned yr;
    int unsigned total_req;

    add_req(CMD_TICK, 0, 0, 0, 0, 0, 0);
    add_req(CMD_SET_TIME, 23, 59, 59, 0, 0, 0);
    add_req(CMD_TICK, 63, 63, 63, 31, 15, 16383);
    add_req(CMD_SET_TIME, 63, 63, 63, 0, 0, 0);
    add_req(CMD_SET_TIME, 24, 60, 60, 0, 0, 0);
    add_req(CMD_SET_TIME, 12, 0, 0, 0, 0, 0);
    add_req(CMD_SET_TIME, 0, 0, 0, 0, 0, 0);
    add_req(CMD_SET_DATE, 0, 0, 0, 29, 2, 2000);
    add_req(CMD_SET_DATE, 0, 0, 0, 31, 0, 0);
    add_req(CMD_SET_DATE, 0, 0, 0, 29, 2, 2100);
    add_req(CMD_SET_TIME, 23, 59, 59, 0, 0, 0);
    add_req(CMD_TICK, 0, 0, 0, 0, 0, 0);
    add_req(CMD_SET_DATE, 0, 0, 0, 31, 1, 2024);
    add_req(CMD_SET_DATE, 0, 0, 0, 31, 4, 2024);
    add_req(CMD_SET_TIME, 23, 59, 59, 0, 0, 0);
    add_req(CMD_TICK, 0, 0, 0, 0, 0, 0);
    add_req(CMD_SET_DATE, 0, 0, 0, 31, 12, YearMax);
    add_req(CMD_SET_TIME, 23, 59, 59, 0, 0, 0);
    add_req(CMD_TICK, 0, 0, 0, 0, 0, 0);
    add_req(CMD_SET_DATE, 0, 0, 0, 31, 12, 1999);
    add_req(CMD_SET_TIME, 23, 59, 59, 0, 0, 0);
    add_req(CMD_TICK, 0, 0, 0, 0, 0, 0);
    add_req(CmdUnknown, 63, 63, 63, 31, 15, 16383);
    add_req(CMD_SET_DATE, 0, 0, 0, 0, 15, 1);

    total_req = pending_q.size() + RandomReqs;
    while (pending_q.size() < total_req) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          add_req(CMD_SET_TIME, $urandom_range(20, 23), $urandom_range(57, 59),
                  $urandom_range(50, 59), $urandom, $urandom, $urandom);
          repeat ($urandom_range(1, 15))
            add_req(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        3, 4: begin
          case ($urandom_range(0, 3))
            0: yr = $urandom_range(1, YearMax);
            1: yr = 100 * $urandom_range(1, 163);
            2: yr = 4 * $urandom_range(1, 4095);
            default: yr = YearMax - $urandom_range(0, 1);
          endcase
          add_req(CMD_SET_DATE, $urandom, $urandom, $urandom, $urandom_range(27, 31),
                  $urandom_range(1, 12), yr);
          add_req(CMD_SET_TIME, 23, 59, $urandom_range(58, 59), $urandom, $urandom, $urandom);
          repeat ($urandom_range(1, 4))
            add_req(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        5, 6: begin
          add_req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
        end
        default: begin
          repeat ($urandom_range(1, 20))
            add_req(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
      endcase
    end
    total_req = pending_q.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cnt < total_req || clock_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (clock_exp_q.size() != 0) begin
      report_error($sformatf("%0d results never arrived", clock_exp_q.size()));
    end
    $display("Sent %0d ticks, %0d set-time, %0d set-date and %0d unknown commands.",
             tick_cnt, set_time_cnt, set_date_cnt, unknown_cnt);
    $display("Compared %0d results; the calendar crossed %0d month boundaries.",
             checked_cnt, month_turns);
    if (error_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
